>>> sv/rbf_pkg.sv
// Shared types and codes for the radial basis network engine.
`default_nettype none

package rbf_pkg;

  typedef struct packed {
    logic [2:0]         func;
    logic [5:0]         neuron;
    logic [3:0]         column;
    logic signed [15:0] value;
    logic               final_feature;
  } rbf_in_t;

  typedef struct packed {
    logic [2:0]         out_index;
    logic signed [31:0] out_value;
    logic               run_end;
  } rbf_out_t;

  localparam logic [2:0] FUNC_CENTER  = 3'd0;
  localparam logic [2:0] FUNC_WIDTH   = 3'd1;
  localparam logic [2:0] FUNC_WEIGHT  = 3'd2;
  localparam logic [2:0] FUNC_FEATURE = 3'd3;
  localparam logic [2:0] FUNC_TEACHER = 3'd4;
  localparam logic [2:0] FUNC_UPDATE  = 3'd5;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 16;

  localparam logic [CFG_AW-1:0] CFG_DIMS    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_CENTERS = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_OUTPUTS = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_RATE    = 2'd3;

endpackage

`default_nettype wire

>>> sv/rbf_network_forward_and_train_core.sv
// Gaussian RBF network engine: sequencer around one shared multiplier and divider.
// Feature item: one step per center in use. Final feature then, per center, runs a
//   divide and one multiply per unit of the exponent's integer part, then one
//   step per center per output. Teacher item: one step per center.
// Update item: swept over every weight slot of the store.
// Sync active-low reset; afterwards a clearing pass over every slot zeroes the
//   gradient store before the first item is taken.
`default_nettype none

module rbf_network_forward_and_train_core #(
  parameter int MAX_CENTERS    = 64,
  parameter int MAX_DIMS       = 16,
  parameter int MAX_OUTPUTS    = 8,
  parameter int EXP_TABLE_BITS = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire rbf_pkg::rbf_in_t            in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output rbf_pkg::rbf_out_t                out_data,
  input  wire logic                        cfg_we,
  input  wire logic [rbf_pkg::CFG_AW-1:0]  cfg_addr,
  input  wire logic [rbf_pkg::CFG_DW-1:0]  cfg_wdata
);
  import rbf_pkg::*;

  localparam int KB     = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
  localparam int DB     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int OB     = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int KCW    = $clog2(MAX_CENTERS + 1);
  localparam int DCW    = $clog2(MAX_DIMS + 1);
  localparam int OCW    = $clog2(MAX_OUTPUTS + 1);
  localparam int CDEPTH = MAX_CENTERS << DB;
  localparam int GA     = KB + OB;
  localparam int GDEPTH = MAX_CENTERS << OB;
  localparam int ROM_N  = 1 << EXP_TABLE_BITS;
  localparam int FRAC_BITS = 16 - EXP_TABLE_BITS;

  typedef logic [30:0] rom_t [0:ROM_N];

  // exp(-i/ROM_N) in Q1.30 from a series truncated after the x^16 term
  function automatic rom_t build_rom();
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    rom_t        r;
    for (int i = 0; i <= ROM_N; i++) begin
      x    = 64'(i) << (30 - EXP_TABLE_BITS);
      term = 64'd1 << 30;
      sum  = 64'd1 << 30;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * x) >> 30) / 64'(n);
        if (n % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      r[i] = 31'(sum);
    end
    return r;
  endfunction

  localparam rom_t        EXP_ROM = build_rom();
  localparam logic [30:0] EXP_E1  = EXP_ROM[ROM_N];

  localparam logic signed [48:0] GRAD_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] GRAD_MIN = -49'sd140737488355328;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD,
    S_F_RD, S_F_MUL, S_F_ACC,
    S_A_RD, S_A_SQ, S_A_DIV0, S_D_PRE, S_D_STEP,
    S_A_ROM, S_A_INT, S_A_EMUL, S_A_ESH, S_A_WR, S_P_CLR,
    S_O_RD, S_O_MUL, S_O_ACC, S_O_EMIT,
    S_T_E, S_T_RD, S_T_MUL, S_T_ACC,
    S_U_RD, S_U_CHK, S_U_MH, S_U_SUM, S_U_WB
  } state_t;

  // registers
  state_t             state_r, state_nxt;
  rbf_in_t            item_r, item_nxt;
  logic [4:0]         dims_r;
  logic [6:0]         centers_r;
  logic [3:0]         outputs_r;
  logic [15:0]        lr_r;
  logic [KCW-1:0]     k_r, k_nxt;
  logic [OCW-1:0]     m_r, m_nxt;
  logic [GA-1:0]      sw_r, sw_nxt;
  logic signed [39:0] acc_r, acc_nxt;
  logic [39:0]        d2_r, d2_nxt;
  logic [30:0]        res_r, res_nxt;
  logic [19:0]        q_r, q_nxt;
  logic [63:0]        rem_r, rem_nxt;
  logic [63:0]        dsh_r, dsh_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               div_act_r, div_act_nxt;
  logic signed [32:0] e_r, e_nxt;
  logic [47:0]        mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [39:0]        plo_r, plo_nxt;
  logic [15:0]        pcnt_r, pcnt_nxt;
  logic [MAX_CENTERS-1:0] dvalid_r, dvalid_nxt;
  logic [MAX_CENTERS-1:0] avalid_r, avalid_nxt;
  logic signed [31:0] ostore_r [MAX_OUTPUTS];
  logic signed [31:0] ostore_nxt [MAX_OUTPUTS];
  rbf_out_t           out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic signed [65:0] mul_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // memories
  logic                    c_we, c_re;
  logic [KB+DB-1:0]        c_addr;
  logic signed [15:0]      c_q;
  logic signed [15:0]      cmem [CDEPTH];
  logic                    s_we, s_re;
  logic [KB-1:0]           s_addr;
  logic signed [15:0]      s_q;
  logic signed [15:0]      smem [MAX_CENTERS];
  logic                    w_we, w_re;
  logic [GA-1:0]           w_addr;
  logic signed [15:0]      w_wd, w_q;
  logic signed [15:0]      wmem [GDEPTH];
  logic                    d_we, d_re;
  logic [KB-1:0]           d_addr;
  logic [39:0]             d_wd, d_q;
  logic [39:0]             dmem [MAX_CENTERS];
  logic                    a_we, a_re;
  logic [KB-1:0]           a_addr;
  logic [15:0]             a_wd, a_q;
  logic [15:0]             amem [MAX_CENTERS];
  logic                    g_we, g_re;
  logic [GA-1:0]           g_addr;
  logic signed [47:0]      g_wd, g_q;
  logic signed [47:0]      gmem [GDEPTH];

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_addr] <= item_r.value;
    if (c_re) c_q <= cmem[c_addr];
  end

  always_ff @(posedge clk) begin
    if (s_we) smem[s_addr] <= item_r.value;
    if (s_re) s_q <= smem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (w_we) wmem[w_addr] <= w_wd;
    if (w_re) w_q <= wmem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (d_we) dmem[d_addr] <= d_wd;
    if (d_re) d_q <= dmem[d_addr];
  end

  always_ff @(posedge clk) begin
    if (a_we) amem[a_addr] <= a_wd;
    if (a_re) a_q <= amem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_addr] <= g_wd;
    if (g_re) g_q <= gmem[g_addr];
  end

  // clamped counts
  logic [KCW-1:0] kc;
  logic [DCW-1:0] dc;
  logic [OCW-1:0] mc;
  assign kc = (centers_r == '0) ? KCW'(1) :
              ((32'(centers_r) > MAX_CENTERS) ? KCW'(MAX_CENTERS) : KCW'(centers_r));
  assign dc = (dims_r == '0) ? DCW'(1) :
              ((32'(dims_r) > MAX_DIMS) ? DCW'(MAX_DIMS) : DCW'(dims_r));
  assign mc = (outputs_r == '0) ? OCW'(1) :
              ((32'(outputs_r) > MAX_OUTPUTS) ? OCW'(MAX_OUTPUTS) : OCW'(outputs_r));

  // indexes and datapath terms
  logic [KB-1:0]      k_idx, nrn;
  logic [OB-1:0]      m_idx, col_o, sw_m;
  logic [DB-1:0]      col_d;
  logic [KB-1:0]      sw_k;
  logic               k_last, m_last, sw_last;
  logic signed [16:0] f_diff;
  logic [39:0]        d_old;
  logic [40:0]        f_sum;
  logic [15:0]        a_cur;
  logic signed [32:0] y_full;
  logic signed [31:0] y_sat;
  logic signed [48:0] t_sum;
  logic [47:0]        g_mag;
  logic signed [18:0] w_new;
  logic               div_ge;
  logic [EXP_TABLE_BITS-1:0] rom_idx;
  logic [FRAC_BITS-1:0]      rom_rem;
  logic [30:0]        rom_lo, rom_hi;
  logic               o_load;

  assign k_idx   = k_r[KB-1:0];
  assign m_idx   = m_r[OB-1:0];
  assign nrn     = KB'(item_r.neuron);
  assign col_d   = DB'(item_r.column);
  assign col_o   = OB'(item_r.column);
  assign sw_k    = sw_r[GA-1:OB];
  assign sw_m    = sw_r[OB-1:0];
  assign k_last  = (k_r == kc - KCW'(1));
  assign m_last  = (m_r == mc - OCW'(1));
  assign sw_last = (sw_r == GA'(GDEPTH - 1));
  assign f_diff  = 17'(item_r.value) - 17'(c_q);
  assign d_old   = dvalid_r[k_idx] ? d_q : 40'd0;
  assign f_sum   = 41'(d_old) + 41'(mul_r[33:0]);
  assign a_cur   = avalid_r[k_idx] ? a_q : 16'd0;
  assign y_full  = 33'(acc_r >>> 7);
  assign y_sat   = (y_full > 33'sd2147483647) ? 32'sh7FFFFFFF :
                   (y_full < -33'sd2147483648) ? 32'sh80000000 : 32'(y_full);
  assign t_sum   = 49'(g_q) + 49'(mul_r >>> 15);
  assign g_mag   = g_q[47] ? 48'(-g_q) : 48'(g_q);
  assign w_new   = neg_r ? (19'(w_q) + $signed({1'b0, q_r[17:0]}))
                         : (19'(w_q) - $signed({1'b0, q_r[17:0]}));
  assign div_ge  = (rem_r >= dsh_r);
  assign rom_idx = q_r[15 -: EXP_TABLE_BITS];
  assign rom_rem = q_r[FRAC_BITS-1:0];
  assign rom_lo  = EXP_ROM[(EXP_TABLE_BITS+1)'(rom_idx)];
  assign rom_hi  = EXP_ROM[(EXP_TABLE_BITS+1)'(rom_idx) + (EXP_TABLE_BITS+1)'(1)];
  assign o_load  = (state_r == S_O_EMIT) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    k_nxt       = k_r;
    m_nxt       = m_r;
    sw_nxt      = sw_r;
    acc_nxt     = acc_r;
    d2_nxt      = d2_r;
    res_nxt     = res_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    dsh_nxt     = dsh_r;
    cnt_nxt     = cnt_r;
    div_act_nxt = div_act_r;
    e_nxt       = e_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    plo_nxt     = plo_r;
    pcnt_nxt    = pcnt_r;
    dvalid_nxt  = dvalid_r;
    avalid_nxt  = avalid_r;
    ostore_nxt  = ostore_r;
    out_nxt     = out_r;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    mul_a  = '0;
    mul_b  = '0;
    c_we = 1'b0; c_re = 1'b0; c_addr = {nrn, col_d};
    s_we = 1'b0; s_re = 1'b0; s_addr = k_idx;
    w_we = 1'b0; w_re = 1'b0; w_addr = {k_idx, m_idx}; w_wd = item_r.value;
    d_we = 1'b0; d_re = 1'b0; d_addr = k_idx; d_wd = f_sum[39:0];
    a_we = 1'b0; a_re = 1'b0; a_addr = k_idx;
    a_wd = 16'((32'(res_r) + 32'd16384) >> 15);
    g_we = 1'b0; g_re = 1'b0; g_addr = sw_r; g_wd = '0;

    unique case (state_r)
      S_CLR: begin
        g_we = 1'b1;
        if (sw_last) begin
          sw_nxt    = '0;
          state_nxt = S_IDLE;
        end else begin
          sw_nxt = sw_r + GA'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          k_nxt    = '0;
          sw_nxt   = '0;
          case (in_data.func)
            FUNC_CENTER, FUNC_WIDTH, FUNC_WEIGHT: state_nxt = S_LOAD;
            FUNC_FEATURE: begin
              if (32'(in_data.column) < 32'(dc)) state_nxt = S_F_RD;
              else if (in_data.final_feature) state_nxt = S_A_RD;
            end
            FUNC_TEACHER: begin
              if (32'(in_data.column) < 32'(mc)) state_nxt = S_T_E;
            end
            FUNC_UPDATE: state_nxt = S_U_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        // drop loads that fall outside the stores
        if (32'(item_r.neuron) < MAX_CENTERS) begin
          case (item_r.func)
            FUNC_CENTER: c_we = (32'(item_r.column) < MAX_DIMS);
            FUNC_WIDTH: begin
              s_we   = 1'b1;
              s_addr = nrn;
            end
            FUNC_WEIGHT: begin
              w_we   = (32'(item_r.column) < MAX_OUTPUTS);
              w_addr = {nrn, col_o};
            end
            default: ;
          endcase
        end
        state_nxt = S_IDLE;
      end
      S_F_RD: begin
        c_re = 1'b1;
        c_addr = {k_idx, col_d};
        d_re = 1'b1;
        state_nxt = S_F_MUL;
      end
      S_F_MUL: begin
        mul_a = 33'(f_diff);
        mul_b = 33'(f_diff);
        state_nxt = S_F_ACC;
      end
      S_F_ACC: begin
        d_we = 1'b1;
        d_wd = f_sum[40] ? {40{1'b1}} : f_sum[39:0];
        dvalid_nxt[k_idx] = 1'b1;
        if (k_last) begin
          k_nxt     = '0;
          state_nxt = item_r.final_feature ? S_A_RD : S_IDLE;
        end else begin
          k_nxt     = k_r + KCW'(1);
          state_nxt = S_F_RD;
        end
      end
      S_A_RD: begin
        d_re = 1'b1;
        s_re = 1'b1;
        state_nxt = S_A_SQ;
      end
      S_A_SQ: begin
        d2_nxt = d_old;
        mul_a  = 33'(s_q);
        mul_b  = 33'(s_q);
        if (s_q == '0) begin
          res_nxt   = (d_old == '0) ? 31'(32'd1 << 30) : '0;
          state_nxt = S_A_WR;
        end else begin
          state_nxt = S_A_DIV0;
        end
      end
      S_A_DIV0: begin
        rem_nxt     = {8'd0, d2_r, 16'd0};
        dsh_nxt     = 64'(mul_r[31:0]) << 21;
        cnt_nxt     = 5'd20;
        q_nxt       = '0;
        div_act_nxt = 1'b1;
        state_nxt   = S_D_PRE;
      end
      S_D_PRE: begin
        // quotient past the range: activation vanishes, or the step saturates
        if (div_ge) begin
          if (div_act_r) begin
            res_nxt   = '0;
            state_nxt = S_A_WR;
          end else begin
            q_nxt     = 20'(32'd1 << 17);
            state_nxt = S_U_WB;
          end
        end else begin
          dsh_nxt   = dsh_r >> 1;
          state_nxt = S_D_STEP;
        end
      end
      S_D_STEP: begin
        if (div_ge) rem_nxt = rem_r - dsh_r;
        q_nxt   = {q_r[18:0], div_ge};
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) state_nxt = div_act_r ? S_A_ROM : S_U_WB;
      end
      S_A_ROM: begin
        mul_a     = 33'(rom_lo - rom_hi);
        mul_b     = 33'(rom_rem);
        res_nxt   = rom_lo;
        state_nxt = S_A_INT;
      end
      S_A_INT: begin
        res_nxt   = res_r - 31'(mul_r >> FRAC_BITS);
        cnt_nxt   = 5'(q_r[19:16]);
        state_nxt = (q_r[19:16] == 4'd0) ? S_A_WR : S_A_EMUL;
      end
      S_A_EMUL: begin
        mul_a     = 33'(res_r);
        mul_b     = 33'(EXP_E1);
        state_nxt = S_A_ESH;
      end
      S_A_ESH: begin
        res_nxt   = 31'(mul_r >> 30);
        cnt_nxt   = cnt_r - 5'd1;
        state_nxt = (cnt_r == 5'd1) ? S_A_WR : S_A_EMUL;
      end
      S_A_WR: begin
        a_we = 1'b1;
        avalid_nxt[k_idx] = 1'b1;
        if (k_last) begin
          state_nxt = S_P_CLR;
        end else begin
          k_nxt     = k_r + KCW'(1);
          state_nxt = S_A_RD;
        end
      end
      S_P_CLR: begin
        dvalid_nxt = '0;
        if (pcnt_r != 16'hFFFF) pcnt_nxt = pcnt_r + 16'd1;
        k_nxt     = '0;
        m_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = S_O_RD;
      end
      S_O_RD: begin
        a_re = 1'b1;
        w_re = 1'b1;
        state_nxt = S_O_MUL;
      end
      S_O_MUL: begin
        mul_a     = 33'(a_cur);
        mul_b     = 33'(w_q);
        state_nxt = S_O_ACC;
      end
      S_O_ACC: begin
        acc_nxt = acc_r + 40'(mul_r);
        if (k_last) begin
          state_nxt = S_O_EMIT;
        end else begin
          k_nxt     = k_r + KCW'(1);
          state_nxt = S_O_RD;
        end
      end
      S_O_EMIT: begin
        if (o_load) begin
          ostore_nxt[m_idx]  = y_sat;
          out_nxt.out_index  = 3'(m_r);
          out_nxt.out_value  = y_sat;
          out_nxt.run_end    = m_last;
          out_valid_nxt      = 1'b1;
          if (m_last) begin
            state_nxt = S_IDLE;
          end else begin
            m_nxt     = m_r + OCW'(1);
            k_nxt     = '0;
            acc_nxt   = '0;
            state_nxt = S_O_RD;
          end
        end
      end
      S_T_E: begin
        e_nxt     = 33'(ostore_r[col_o]) - (33'(item_r.value) <<< 8);
        state_nxt = S_T_RD;
      end
      S_T_RD: begin
        a_re   = 1'b1;
        g_re   = 1'b1;
        g_addr = {k_idx, col_o};
        state_nxt = S_T_MUL;
      end
      S_T_MUL: begin
        mul_a     = e_r;
        mul_b     = 33'(a_cur);
        state_nxt = S_T_ACC;
      end
      S_T_ACC: begin
        g_we   = 1'b1;
        g_addr = {k_idx, col_o};
        g_wd   = (t_sum > GRAD_MAX) ? 48'(GRAD_MAX) :
                 (t_sum < GRAD_MIN) ? 48'(GRAD_MIN) : 48'(t_sum);
        if (k_last) begin
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + KCW'(1);
          state_nxt = S_T_RD;
        end
      end
      S_U_RD: begin
        g_re   = 1'b1;
        w_re   = 1'b1;
        w_addr = sw_r;
        state_nxt = S_U_CHK;
      end
      S_U_CHK: begin
        if ((32'(sw_k) < 32'(kc)) && (32'(sw_m) < 32'(mc))) begin
          neg_nxt   = g_q[47];
          mag_nxt   = g_mag;
          mul_a     = 33'(g_mag[23:0]);
          mul_b     = 33'(lr_r);
          state_nxt = S_U_MH;
        end else begin
          // slot not in use: only clear its gradient
          g_we = 1'b1;
          if (sw_last) begin
            pcnt_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            sw_nxt    = sw_r + GA'(1);
            state_nxt = S_U_RD;
          end
        end
      end
      S_U_MH: begin
        plo_nxt   = mul_r[39:0];
        mul_a     = 33'(mag_r[47:24]);
        mul_b     = 33'(lr_r);
        state_nxt = S_U_SUM;
      end
      S_U_SUM: begin
        rem_nxt     = (64'(mul_r[39:0]) << 24) + 64'(plo_r);
        dsh_nxt     = 64'((pcnt_r == '0) ? 16'd1 : pcnt_r) << 41;
        cnt_nxt     = 5'd17;
        q_nxt       = '0;
        div_act_nxt = 1'b0;
        state_nxt   = S_D_PRE;
      end
      S_U_WB: begin
        w_we   = 1'b1;
        w_addr = sw_r;
        w_wd   = (w_new > 19'sd32767) ? 16'sh7FFF :
                 (w_new < -19'sd32768) ? 16'sh8000 : 16'(w_new);
        g_we   = 1'b1;
        if (sw_last) begin
          pcnt_nxt  = '0;
          state_nxt = S_IDLE;
        end else begin
          sw_nxt    = sw_r + GA'(1);
          state_nxt = S_U_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      sw_r        <= '0;
      dims_r      <= 5'd16;
      centers_r   <= 7'd64;
      outputs_r   <= 4'd8;
      lr_r        <= 16'd655;
      pcnt_r      <= '0;
      dvalid_r    <= '0;
      avalid_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_OUTPUTS; i++) ostore_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      pcnt_r      <= pcnt_nxt;
      dvalid_r    <= dvalid_nxt;
      avalid_r    <= avalid_nxt;
      out_valid_r <= out_valid_nxt;
      ostore_r    <= ostore_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_DIMS:    dims_r    <= cfg_wdata[4:0];
          CFG_CENTERS: centers_r <= cfg_wdata[6:0];
          CFG_OUTPUTS: outputs_r <= cfg_wdata[3:0];
          CFG_RATE:    lr_r      <= cfg_wdata;
          default: ;
        endcase
      end
    end
    item_r    <= item_nxt;
    k_r       <= k_nxt;
    m_r       <= m_nxt;
    acc_r     <= acc_nxt;
    d2_r      <= d2_nxt;
    res_r     <= res_nxt;
    q_r       <= q_nxt;
    rem_r     <= rem_nxt;
    dsh_r     <= dsh_nxt;
    cnt_r     <= cnt_nxt;
    div_act_r <= div_act_nxt;
    e_r       <= e_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    plo_r     <= plo_nxt;
    out_r     <= out_nxt;
    mul_r     <= mul_p;
  end

  a_dist_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_P_CLR |=> dvalid_r == '0)
    else $error("distance valid bits not cleared after pattern");

  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    o_load && m_last |=> state_r == S_IDLE && out_valid && out_data.run_end)
    else $error("last output of pattern not marked or sequencer not idle");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_D_STEP |-> cnt_r != 5'd0)
    else $error("divider step with exhausted count");

endmodule

`default_nettype wire

>>> tb/sv/tb_rbf_network_forward_and_train_core.sv
// Self-checking testbench for the radial basis network engine: directed table, then random traffic.
`default_nettype none

module tb_rbf_network_forward_and_train_core;
  timeunit 1ns;
  timeprecision 1ps;

  import rbf_pkg::*;

  localparam int NC = 64;
  localparam int ND = 16;
  localparam int NO = 8;
  localparam int TB = 6;
  localparam int FB = 16 - TB;
  localparam int QUIET_LIMIT = 60000;
  localparam logic [2:0] FUNC_BAD6 = 3'd6;
  localparam logic [2:0] FUNC_BAD7 = 3'd7;
  localparam longint DIST_SAT = (64'sd1 <<< 40) - 1;
  localparam longint GRAD_HI = (64'sd1 <<< 47) - 1;
  localparam longint GRAD_LO = -(64'sd1 <<< 47);

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rbf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rbf_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = CFG_DIMS;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  rbf_network_forward_and_train_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mirror of the engine state
  logic [63:0] exp_rom [0:(1<<TB)];
  logic signed [15:0] center_mem [0:NC*ND-1];
  logic signed [15:0] width_mem [0:NC-1];
  logic signed [15:0] weight_mem [0:NC*NO-1];
  bit center_set [0:NC*ND-1];
  bit width_set [0:NC-1];
  bit weight_set [0:NC*NO-1];
  longint dist_acc [0:NC-1];
  int unsigned act_mem [0:NC-1];
  logic signed [31:0] net_out [0:NO-1];
  longint grad_acc [0:NC*NO-1];
  int unsigned pat_count;
  logic [4:0] dims_reg;
  logic [6:0] centers_reg;
  logic [3:0] outputs_reg;
  logic [15:0] rate_reg;

  rbf_out_t want_q [$];
  int fails = 0;
  int n_results = 0;
  int n_items = 0;
  int n_patterns = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet = 0;

  function automatic int eff(int raw, int maxv);
    if (raw < 1) return 1;
    if (raw > maxv) return maxv;
    return raw;
  endfunction

  function automatic void build_exp_rom();
    longint unsigned x, term, sum;
    for (int i = 0; i <= (1 << TB); i++) begin
      x = longint'(i) << (30 - TB);
      term = 64'd1 << 30;
      sum = term;
      for (int n = 1; n <= 16; n++) begin
        term = ((term * x) >> 30) / n;
        if (n & 1) sum = sum - term;
        else sum = sum + term;
      end
      exp_rom[i] = sum;
    end
  endfunction

  function automatic int unsigned gauss(longint unsigned d2, logic signed [15:0] s);
    longint sl, s2;
    longint unsigned a, f, idx, rem, res;
    sl = s;
    s2 = sl * sl;
    if (s2 == 0) return (d2 == 0) ? 32768 : 0;
    a = (d2 << 16) / (2 * longint'(s2));
    if (a >= (64'd16 << 16)) return 0;
    f = a & 64'hFFFF;
    idx = f >> FB;
    rem = f & ((64'd1 << FB) - 1);
    res = exp_rom[idx] - (((exp_rom[idx] - exp_rom[idx+1]) * rem) >> FB);
    for (longint unsigned n = a >> 16; n > 0; n--)
      res = (res * exp_rom[1 << TB]) >> 30;
    return int'((res + (64'd1 << 14)) >> 15);
  endfunction

  // Apply one accepted item to the mirror; push the outputs it produces when asked
  function automatic void rbf_predict(rbf_in_t it, bit push);
    int kc, mc, dc, k, m;
    longint v, d, acc, sum, y, e, g, w, p;
    longint unsigned mag, delta;
    rbf_out_t r;
    kc = eff(centers_reg, NC);
    mc = eff(outputs_reg, NO);
    dc = eff(dims_reg, ND);
    v = it.value;
    case (it.func)
      FUNC_CENTER: begin
        center_mem[it.neuron*ND + it.column] = it.value;
        center_set[it.neuron*ND + it.column] = 1'b1;
      end
      FUNC_WIDTH: begin
        width_mem[it.neuron] = it.value;
        width_set[it.neuron] = 1'b1;
      end
      FUNC_WEIGHT: begin
        if (it.column < NO) begin
          weight_mem[it.neuron*NO + it.column] = it.value;
          weight_set[it.neuron*NO + it.column] = 1'b1;
        end
      end
      FUNC_FEATURE: begin
        if (it.column < dc)
          for (k = 0; k < kc; k++) begin
            d = v - longint'(center_mem[k*ND + it.column]);
            acc = dist_acc[k] + d * d;
            dist_acc[k] = (acc > DIST_SAT) ? DIST_SAT : acc;
          end
        if (it.final_feature) begin
          for (k = 0; k < kc; k++) act_mem[k] = gauss(dist_acc[k], width_mem[k]);
          for (k = 0; k < NC; k++) dist_acc[k] = 0;
          if (pat_count < 65535) pat_count++;
          for (m = 0; m < mc; m++) begin
            sum = 0;
            for (k = 0; k < kc; k++) begin
              w = weight_mem[k*NO + m];
              sum += longint'(act_mem[k]) * w;
            end
            y = sum >>> 7;
            if (y > 64'sd2147483647) y = 64'sd2147483647;
            if (y < -64'sd2147483648) y = -64'sd2147483648;
            net_out[m] = y[31:0];
            r.out_index = m[2:0];
            r.out_value = y[31:0];
            r.run_end = (m + 1 == mc);
            if (push) want_q.push_back(r);
          end
        end
      end
      FUNC_TEACHER: begin
        if (it.column < mc) begin
          e = longint'(net_out[it.column]) - v * 256;
          for (k = 0; k < kc; k++) begin
            g = grad_acc[k*NO + it.column] + ((e * longint'(act_mem[k])) >>> 15);
            if (g > GRAD_HI) g = GRAD_HI;
            if (g < GRAD_LO) g = GRAD_LO;
            grad_acc[k*NO + it.column] = g;
          end
        end
      end
      FUNC_UPDATE: begin
        p = (pat_count != 0) ? pat_count : 1;
        for (k = 0; k < kc; k++)
          for (m = 0; m < mc; m++) begin
            g = grad_acc[k*NO + m];
            mag = (g < 0) ? -g : g;
            delta = ((mag * rate_reg) / p) >> 24;
            w = weight_mem[k*NO + m];
            w = (g < 0) ? w + longint'(delta) : w - longint'(delta);
            if (w > 32767) w = 32767;
            if (w < -32768) w = -32768;
            weight_mem[k*NO + m] = w[15:0];
          end
        for (k = 0; k < NC*NO; k++) grad_acc[k] = 0;
        pat_count = 0;
      end
      default: ;
    endcase
  endfunction

  // Receiver: check transfers, stall at random or for a long hold; watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected output idx=%0d val=%0d end=%0b", $time,
                 out_data.out_index, out_data.out_value, out_data.run_end);
        fails++;
      end else begin
        if (out_data !== want_q[0]) begin
          $display("%0t: mismatch expected idx=%0d val=%0d end=%0b actual idx=%0d val=%0d end=%0b",
                   $time, want_q[0].out_index, want_q[0].out_value, want_q[0].run_end,
                   out_data.out_index, out_data.out_value, out_data.run_end);
          fails++;
        end
        void'(want_q.pop_front());
      end
    end
    if (hold_req != 0 && hold_left == 0) begin
      hold_left <= hold_req;
      hold_req = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(rbf_in_t it, bit push);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    rbf_predict(it, push);
    if (it.func != FUNC_BAD6 && it.func != FUNC_BAD7) n_items++;
  endtask

  task automatic drain(int extra);
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_regs(int d, int c, int o, int r);
    logic [CFG_DW-1:0] vals [4];
    logic [CFG_AW-1:0] regs [4];
    vals = '{d, c, o, r};
    regs = '{CFG_DIMS, CFG_CENTERS, CFG_OUTPUTS, CFG_RATE};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    dims_reg = d;
    centers_reg = c;
    outputs_reg = o;
    rate_reg = r;
  endtask

  function automatic logic signed [15:0] rand_value();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 1023) - 512;
    return $urandom();
  endfunction

  function automatic logic signed [15:0] rand_width();
    logic signed [15:0] s;
    if ($urandom_range(0, 99) < 15) return 16'sd0;
    s = $urandom_range(64, 2048);
    return $urandom_range(0, 1) ? -s : s;
  endfunction

  function automatic rbf_in_t mk(logic [2:0] f, int n, int c, logic signed [15:0] v, bit fin);
    rbf_in_t it;
    it.func = f;
    it.neuron = n;
    it.column = c;
    it.value = v;
    it.final_feature = fin;
    return it;
  endfunction

  // Fill every store slot that the current sizes can read
  task automatic fill_stores();
    int kc, dc, mc;
    kc = eff(centers_reg, NC);
    dc = eff(dims_reg, ND);
    mc = eff(outputs_reg, NO);
    for (int k = 0; k < kc; k++) begin
      if (!width_set[k]) send(mk(FUNC_WIDTH, k, 0, rand_width(), 0), 1);
      for (int d = 0; d < dc; d++)
        if (!center_set[k*ND + d]) send(mk(FUNC_CENTER, k, d, rand_value(), 0), 1);
      for (int m = 0; m < mc; m++)
        if (!weight_set[k*NO + m]) send(mk(FUNC_WEIGHT, k, m, rand_value(), 0), 1);
    end
  endtask

  task automatic send_pattern();
    int dc;
    dc = eff(dims_reg, ND);
    for (int d = 0; d < dc; d++) begin
      if (dc < ND && $urandom_range(0, 9) == 0)
        send(mk(FUNC_FEATURE, $urandom(), $urandom_range(dc, ND-1), $urandom(), 0), 1);
      send(mk(FUNC_FEATURE, $urandom(), d, rand_value(), d == dc - 1), 1);
    end
    n_patterns++;
  endtask

  typedef struct {
    rbf_in_t it;
    bit typed;
    logic signed [31:0] want;
  } row_t;

  row_t rows [26];
  int ph_dims [6] = '{3, 0, 16, 1, 31, 2};
  int ph_cent [6] = '{4, 1, 3, 64, 5, 127};
  int ph_outs [6] = '{3, 1, 8, 1, 15, 0};
  int ph_rate [6] = '{655, 0, 30000, 1000, 4096, 65535};

  initial begin
    int sel, start, mc;
    rbf_out_t r;
    build_exp_rom();
    for (int i = 0; i < NC*ND; i++) begin center_mem[i] = 0; center_set[i] = 0; end
    for (int i = 0; i < NC*NO; i++) begin
      weight_mem[i] = 0; weight_set[i] = 0; grad_acc[i] = 0;
    end
    for (int i = 0; i < NC; i++) begin
      width_mem[i] = 0; width_set[i] = 0; dist_acc[i] = 0; act_mem[i] = 0;
    end
    for (int i = 0; i < NO; i++) net_out[i] = 0;
    pat_count = 0;
    dims_reg = 16; centers_reg = 64; outputs_reg = 8; rate_reg = 655;

    rows = '{
      '{mk(FUNC_CENTER, 0, 0, 16'sh0100, 0), 0, 0},
      '{mk(FUNC_WIDTH, 0, 0, 16'sh0100, 0), 0, 0},
      '{mk(FUNC_WEIGHT, 0, 0, 16'sh0100, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh0100, 1), 1, 32'sd65536},
      '{mk(FUNC_FEATURE, 0, 9, 16'sh7fff, 1), 1, 32'sd65536},
      '{mk(FUNC_WEIGHT, 0, 9, 16'sh1234, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh0180, 1), 0, 0},
      '{mk(FUNC_TEACHER, 0, 0, 16'sh7fff, 0), 0, 0},
      '{mk(FUNC_TEACHER, 0, 0, -16'sh8000, 0), 0, 0},
      '{mk(FUNC_TEACHER, 0, 12, 16'sh0000, 0), 0, 0},
      '{mk(FUNC_UPDATE, 0, 0, 16'sh0000, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh0100, 1), 0, 0},
      '{mk(FUNC_WIDTH, 63, 15, 16'sh0000, 1), 0, 0},
      '{mk(FUNC_WIDTH, 0, 0, 16'sh0000, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh0100, 1), 0, 0},
      '{mk(FUNC_WEIGHT, 0, 0, 16'sh7fff, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh0100, 1), 1, 32'sd8388352},
      '{mk(FUNC_WEIGHT, 0, 0, -16'sh8000, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh0100, 1), 1, -32'sd8388608},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh7fff, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, -16'sh8000, 1), 1, 32'sd0},
      '{mk(FUNC_BAD6, 63, 15, -16'sh0001, 1), 0, 0},
      '{mk(FUNC_BAD7, 63, 15, -16'sh0001, 1), 0, 0},
      '{mk(FUNC_CENTER, 0, 0, -16'sh8000, 0), 0, 0},
      '{mk(FUNC_WIDTH, 0, 0, 16'sh7fff, 0), 0, 0},
      '{mk(FUNC_FEATURE, 0, 0, 16'sh7fff, 1), 0, 0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 16;
    rx_idle_pct = 56;
    set_regs(1, 1, 1, 65535);
    foreach (rows[i]) begin
      send(rows[i].it, !rows[i].typed);
      if (rows[i].typed) begin
        r.out_index = 0;
        r.out_value = rows[i].want;
        r.run_end = 1'b1;
        want_q.push_back(r);
      end
    end
    drain(300);

    for (int ph = 0; ph < 6; ph++) begin
      tx_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 56 : 0;
      rx_idle_pct = (ph < 2) ? 56 : (ph < 4) ? 16 : 0;
      set_regs(ph_dims[ph], ph_cent[ph], ph_outs[ph], ph_rate[ph]);
      fill_stores();
      mc = eff(outputs_reg, NO);
      start = n_items;
      while (n_items - start < 65) begin
        if (ph == 1 && n_items - start > 30 && n_items - start < 33) hold_req = 400;
        if (ph == 3 && n_items - start > 30 && n_items - start < 33) drain(0);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          send_pattern();
          if ($urandom_range(0, 1))
            for (int m = 0; m < mc; m++)
              send(mk(FUNC_TEACHER, $urandom(), m, rand_value(), $urandom()), 1);
        end else if (sel < 70) begin
          send(mk(FUNC_TEACHER, $urandom(), $urandom_range(0, 15), rand_value(), $urandom()), 1);
        end else if (sel < 85) begin
          case ($urandom_range(0, 2))
            0: send(mk(FUNC_CENTER, $urandom(), $urandom(), rand_value(), $urandom()), 1);
            1: send(mk(FUNC_WIDTH, $urandom(), $urandom(), rand_width(), $urandom()), 1);
            default: send(mk(FUNC_WEIGHT, $urandom(), $urandom(), rand_value(), $urandom()), 1);
          endcase
        end else if (sel < 88) begin
          send(mk(FUNC_UPDATE, $urandom(), $urandom(), $urandom(), $urandom()), 1);
        end else if (sel < 94) begin
          send(mk($urandom_range(0, 1) ? FUNC_BAD6 : FUNC_BAD7, $urandom(), $urandom(),
                  $urandom(), $urandom()), 1);
        end else begin
          // lone feature: any column, final mark at random
          send(mk(FUNC_FEATURE, $urandom(), $urandom_range(0, 15), $urandom(), $urandom()), 1);
        end
      end
      send_pattern();
      drain(300);
    end

    $display("Covered %0d items, %0d patterns, %0d outputs checked over 7 register settings.",
             n_items, n_patterns, n_results);
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
